>>> hw/rtl/lkcp_pkg.sv
package lkcp_pkg;

  localparam int LANE_COUNT_DEF = 3;

  // field widths
  localparam int POS_W   = 19;
  localparam int LAT_W   = 12;
  localparam int VEL_W   = 13;
  localparam int PTS_W   = 8;
  localparam int SPEED_W = 16;
  localparam int STEP_W  = 12;
  localparam int GAP_W   = 14;
  localparam int TOL_W   = 8;

  // serial datapath widths
  localparam int SQ_W    = 26;  // vx*vx + vy*vy
  localparam int ROOT_W  = 13;  // floor sqrt of that sum
  localparam int REM_W   = 14;  // sqrt partial remainder, at most twice the root
  localparam int PROD_W  = 22;  // points * speed, padded to whole radix-4 digits
  localparam int PROJ_W  = 15;  // projection after the divide
  localparam int DIV_REM_W = 6;
  localparam int CNT_W   = 4;

  localparam int SQ_DIGITS   = (VEL_W + 1) / 2;
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int MUL_DIGITS  = PTS_W / 2;
  localparam int DIV_DIGITS  = PROD_W / 2;
  localparam int DIV_CONST   = 50;  // 0.02 s per path point

  localparam logic [STEP_W-1:0]  STEP_RST  = 12'd229;
  localparam logic [SPEED_W-1:0] LIMIT_RST = 16'd50688;
  localparam logic [GAP_W-1:0]   GAP_RST   = 14'd1920;
  localparam logic [TOL_W-1:0]   TOL_RST   = 8'd7;

  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_CAR    = 2'd1,
    ACT_DECIDE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_KEEP  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_SPEED_STEP  = 2'd0,
    REG_SPEED_LIMIT = 2'd1,
    REG_GAP         = 2'd2,
    REG_CENTRE_TOL  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] other_s;
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
  } car_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic near;
  } car_stat_t;

  // one radix-4 digit times a multiplicand
  function automatic logic [SQ_W-1:0] mul_digit(input logic [SQ_W-1:0] a,
                                                input logic [1:0] d);
    logic [SQ_W-1:0] r;
    r = '0;
    if (d[0]) r = r + a;
    if (d[1]) r = r + {a[SQ_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

>>> hw/rtl/lkcp_isqrt.sv
module lkcp_isqrt
  import lkcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   xs;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;

  // bring down two radicand bits, try root*4+1
  assign shifted = {rem, xs[SQ_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        xs   <= x;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        xs <= {xs[SQ_W-3:0], 2'b00};
        if (shifted >= trial) begin
          rem  <= REM_W'(shifted - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(shifted);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/lkcp_car_eval.sv
module lkcp_car_eval
  import lkcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  car_req_t         req,
  input  logic [PTS_W-1:0] points,
  input  logic [POS_W-1:0] ref_s,
  input  logic [GAP_W-1:0] gap,
  output car_stat_t        stat
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_CMP    = 6'b100000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [POS_W-1:0]    s_hold;
  logic [VEL_W-1:0]    mx, my;
  logic [SQ_W-1:0]     ax, ay, acc;
  logic                sq_start;
  logic                root_done;
  logic [ROOT_W-1:0]   root;
  logic [PROD_W-1:0]   mc, prod, prod_add, dv, q;
  logic [PTS_W-1:0]    mp;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_REM_W+1:0] r4, sub;
  logic [1:0]          qd;
  logic [VEL_W-1:0]    vx_mag, vy_mag;
  logic [POS_W:0]      p_pos, p_diff;
  logic                near;

  assign vx_mag = req.vx[VEL_W-1] ? VEL_W'(-req.vx) : req.vx;
  assign vy_mag = req.vy[VEL_W-1] ? VEL_W'(-req.vy) : req.vy;

  assign prod_add = prod + PROD_W'(mul_digit(SQ_W'(mc), mp[1:0]));

  // radix-4 divide by the path point rate
  assign r4 = {rem, dv[PROD_W-1 -: 2]};
  always_comb begin
    if (r4 >= (DIV_REM_W+2)'(3 * DIV_CONST)) begin
      qd = 2'd3; sub = (DIV_REM_W+2)'(3 * DIV_CONST);
    end else if (r4 >= (DIV_REM_W+2)'(2 * DIV_CONST)) begin
      qd = 2'd2; sub = (DIV_REM_W+2)'(2 * DIV_CONST);
    end else if (r4 >= (DIV_REM_W+2)'(DIV_CONST)) begin
      qd = 2'd1; sub = (DIV_REM_W+2)'(DIV_CONST);
    end else begin
      qd = 2'd0; sub = '0;
    end
  end

  assign p_pos  = {1'b0, s_hold} + (POS_W+1)'(q[PROJ_W-1:0]);
  assign p_diff = p_pos - {1'b0, ref_s};
  assign near   = (p_pos > {1'b0, ref_s}) && (p_diff < (POS_W+1)'(gap));

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_CMP);
  assign stat.near = near;

  lkcp_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (acc),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            s_hold <= req.other_s;
            mx     <= vx_mag;
            my     <= vy_mag;
            ax     <= SQ_W'(vx_mag);
            ay     <= SQ_W'(vy_mag);
            acc    <= '0;
            cnt    <= '0;
            state  <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          acc <= acc + mul_digit(ax, mx[1:0]) + mul_digit(ay, my[1:0]);
          mx  <= mx >> 2;
          my  <= my >> 2;
          ax  <= {ax[SQ_W-3:0], 2'b00};
          ay  <= {ay[SQ_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQ_DIGITS - 1)) begin
            sq_start <= 1'b1;
            state    <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            mc    <= PROD_W'(root);
            mp    <= points;
            prod  <= '0;
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= prod_add;
          mp   <= mp >> 2;
          mc   <= {mc[PROD_W-3:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
            dv    <= prod_add;
            rem   <= '0;
            q     <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= DIV_REM_W'(r4 - sub);
          q   <= {q[PROD_W-3:0], qd};
          dv  <= {dv[PROD_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_DIGITS - 1)) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/lane_keep_change_planner_unit.sv
// channel   | direction | handshake                   | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: ego and sensed car, tuser: action
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: mode, lane, speed, car ahead
// cfg       | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// begin, decide and out-of-lane car items leave the car evaluator idle
// a car in the ego lane holds s_axis_tready low while it is evaluated: 7 radix-4 square digits,
// 13 sqrt bit steps, the sqrt start/done handoff, 4 multiply digits, 11 radix-4
// divide digits and compare, so the next transaction is taken once the compare is over
// rst is synchronous: config registers return to defaults, lane to the middle one
// the result sits in an output register; any s_axis input waits while it is held; cfg_ready is high
module lane_keep_change_planner_unit
  import lkcp_pkg::*;
#(
  parameter int LANE_COUNT = LANE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // path_points[7:0], ego_s[26:8], ego_d[38:27], path_end_s[57:39], other_s[76:58],
  // other_d[88:77], other_vx[101:89], other_vy[114:102], zero[119:115]
  input  logic [119:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mode[1:0], target_lane[3:2], ref_speed[19:4], car_ahead[20], zero[23:21]
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [STEP_W-1:0]  speed_step;
  logic [SPEED_W-1:0] speed_limit;
  logic [GAP_W-1:0]   gap_distance;
  logic [TOL_W-1:0]   centre_tolerance;

  mode_t              mode_reg, mode_next;
  logic [1:0]         lane_reg, lane_next;
  logic [SPEED_W-1:0] speed_reg, speed_next;
  logic               near_flag;
  logic [PTS_W-1:0]   frame_points;
  logic [POS_W-1:0]   frame_ref_s;
  logic [LAT_W-1:0]   frame_ego_d;

  logic [PTS_W-1:0]   in_points;
  logic [POS_W-1:0]   in_ego_s, in_end_s, in_other_s;
  logic [LAT_W-1:0]   in_ego_d, in_other_d;
  logic [VEL_W-1:0]   in_vx, in_vy;
  action_t            action;

  logic               s_accept, cfg_accept;
  logic signed [LAT_W:0] centre, other_d_ext, diff;
  logic [LAT_W-1:0]   mag;
  logic               in_lane;
  logic [SPEED_W:0]   speed_sum;
  car_req_t           car_req;
  car_stat_t          car_stat;

  assign in_points  = s_axis_tdata[7:0];
  assign in_ego_s   = s_axis_tdata[26:8];
  assign in_ego_d   = s_axis_tdata[38:27];
  assign in_end_s   = s_axis_tdata[57:39];
  assign in_other_s = s_axis_tdata[76:58];
  assign in_other_d = s_axis_tdata[88:77];
  assign in_vx      = s_axis_tdata[101:89];
  assign in_vy      = s_axis_tdata[114:102];
  assign action     = action_t'(s_axis_tuser);

  assign s_axis_tready = !car_stat.busy && (!m_axis_tvalid || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_accept    = cfg_valid && cfg_ready;

  // lane centre is 2 m + 4 m per lane
  assign centre      = $signed({3'b000, lane_reg, 8'h80});
  assign other_d_ext = $signed({in_other_d[LAT_W-1], in_other_d});
  assign in_lane     = (other_d_ext < centre + 13'sd128) && (other_d_ext > centre - 13'sd128);

  assign car_req.start   = s_accept && (action == ACT_CAR) && in_lane;
  assign car_req.other_s = in_other_s;
  assign car_req.vx      = in_vx;
  assign car_req.vy      = in_vy;

  lkcp_car_eval u_car_eval (
    .clk    (clk),
    .rst    (rst),
    .req    (car_req),
    .points (frame_points),
    .ref_s  (frame_ref_s),
    .gap    (gap_distance),
    .stat   (car_stat)
  );

  assign diff      = $signed({frame_ego_d[LAT_W-1], frame_ego_d}) - centre;
  assign mag       = diff[LAT_W] ? LAT_W'(-diff) : LAT_W'(diff);
  assign speed_sum = {1'b0, speed_reg} + (SPEED_W+1)'(speed_step);

  always_comb begin
    mode_next  = mode_reg;
    lane_next  = lane_reg;
    speed_next = speed_reg;
    case (mode_reg)
      MODE_KEEP: begin
        if (near_flag) begin
          if (lane_reg != 2'd0) begin
            lane_next = 2'd0;
            mode_next = MODE_LEFT;
          end
          speed_next = (speed_reg > SPEED_W'(speed_step)) ?
                       SPEED_W'(speed_reg - SPEED_W'(speed_step)) : '0;
        end else if (speed_reg < speed_limit) begin
          speed_next = speed_sum[SPEED_W] ? '1 : speed_sum[SPEED_W-1:0];
        end
      end
      MODE_LEFT, MODE_RIGHT: begin
        if (mag < LAT_W'(centre_tolerance)) mode_next = MODE_KEEP;
      end
      default: begin
        mode_next = mode_reg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_step       <= STEP_RST;
      speed_limit      <= LIMIT_RST;
      gap_distance     <= GAP_RST;
      centre_tolerance <= TOL_RST;
    end else if (cfg_accept) begin
      case (reg_index_t'(cfg_index))
        REG_SPEED_STEP:  speed_step       <= cfg_data[STEP_W-1:0];
        REG_SPEED_LIMIT: speed_limit      <= cfg_data[SPEED_W-1:0];
        REG_GAP:         gap_distance     <= cfg_data[GAP_W-1:0];
        REG_CENTRE_TOL:  centre_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_KEEP;
      lane_reg      <= 2'(LANE_COUNT / 2);
      speed_reg     <= '0;
      near_flag     <= 1'b0;
      frame_points  <= '0;
      frame_ref_s   <= '0;
      frame_ego_d   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_accept && (action == ACT_DECIDE)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (car_stat.done && car_stat.near) near_flag <= 1'b1;
      if (s_accept) begin
        case (action)
          ACT_BEGIN: begin
            frame_points <= in_points;
            frame_ego_d  <= in_ego_d;
            frame_ref_s  <= (in_points != '0) ? in_end_s : in_ego_s;
            near_flag    <= 1'b0;
          end
          ACT_DECIDE: begin
            mode_reg  <= mode_next;
            lane_reg  <= lane_next;
            speed_reg <= speed_next;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && (action == ACT_DECIDE)) begin
      m_axis_tdata <= {3'b000, near_flag, speed_next, lane_next, mode_next};
    end
  end

endmodule

>>> hw/rtl/lkcp_checker.sv
module lkcp_props
  import lkcp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata
);

  // held result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result changed");

  // a new result only follows an accepted decide
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_DECIDE)))
    else $error("result without decide");

  // change right is never entered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != MODE_RIGHT) && (m_axis_tdata[1:0] != 2'd3))
    else $error("bad mode in result");

  // a left change aims at lane zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == MODE_LEFT) |-> m_axis_tdata[3:2] == 2'd0)
    else $error("left change with nonzero lane");

  // no input transaction while a result is held
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

endmodule

bind lane_keep_change_planner_unit lkcp_props u_lkcp_props (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/lkcp_checker.sv
module lkcp_checker
  import lkcp_pkg::*;
#(
  parameter int LANE_COUNT = LANE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // path_points[7:0], ego_s[26:8], ego_d[38:27], path_end_s[57:39], other_s[76:58],
  // other_d[88:77], other_vx[101:89], other_vy[114:102], zero[119:115]
  input  logic [119:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mode[1:0], target_lane[3:2], ref_speed[19:4], car_ahead[20], zero[23:21]
  input  logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           owed,
  output int           mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mode_t       mode;
    logic [1:0]  lane;
    logic [15:0] speed;
    logic        near;
  } decision_t;

  decision_t decisions_due[$];
  int errs = 0;

  int unsigned step_cfg, limit_cfg, gap_cfg, tol_cfg;
  mode_t       plan_mode;
  int          plan_lane;
  int unsigned plan_speed;
  logic        plan_near;
  int unsigned frame_pts;
  int unsigned frame_ref;
  int          frame_d;

  task automatic reset_plan();
    step_cfg   = STEP_RST;
    limit_cfg  = LIMIT_RST;
    gap_cfg    = GAP_RST;
    tol_cfg    = TOL_RST;
    plan_mode  = MODE_KEEP;
    plan_lane  = (LANE_COUNT / 2) % 4;
    plan_speed = 0;
    plan_near  = 1'b0;
    frame_pts  = 0;
    frame_ref  = 0;
    frame_d    = 0;
  endtask

  // bitwise floor square root
  function automatic int unsigned root_floor(input int unsigned x);
    int unsigned rem, r, b;
    rem = x;
    r = 0;
    b = 32'd1 << 30;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic plan_item(input logic [1:0] act, input logic [119:0] w);
    int          d, centre, vx, vy, diff;
    int unsigned sq, proj, p, mag;
    decision_t   dec;
    centre = 128 + 256 * plan_lane;
    case (act)
      ACT_BEGIN: begin
        frame_pts = w[7:0];
        frame_d   = $signed(w[38:27]);
        frame_ref = (frame_pts != 0) ? w[57:39] : w[26:8];
        plan_near = 1'b0;
      end
      ACT_CAR: begin
        d = $signed(w[88:77]);
        if (d < centre + 128 && d > centre - 128) begin
          vx   = $signed(w[101:89]);
          vy   = $signed(w[114:102]);
          sq   = vx * vx + vy * vy;
          proj = (frame_pts * root_floor(sq)) / 50;
          p    = w[76:58] + proj;
          if (p > frame_ref && (p - frame_ref) < gap_cfg) plan_near = 1'b1;
        end
      end
      ACT_DECIDE: begin
        if (plan_mode == MODE_KEEP) begin
          if (plan_near) begin
            if (plan_lane > 0) begin
              plan_lane = 0;
              plan_mode = MODE_LEFT;
            end
            plan_speed = (plan_speed > step_cfg) ? plan_speed - step_cfg : 0;
          end else if (plan_speed < limit_cfg) begin
            plan_speed = plan_speed + step_cfg;
            if (plan_speed > 65535) plan_speed = 65535;
          end
        end else if (plan_mode == MODE_LEFT || plan_mode == MODE_RIGHT) begin
          diff = frame_d - centre;
          mag  = (diff < 0) ? -diff : diff;
          if (mag < tol_cfg) plan_mode = MODE_KEEP;
        end
        dec.mode  = plan_mode;
        dec.lane  = plan_lane[1:0];
        dec.speed = plan_speed[15:0];
        dec.near  = plan_near;
        decisions_due.push_back(dec);
      end
      default: ;  // spare action code is dropped
    endcase
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    decision_t dec;
    if (rst) begin
      reset_plan();
      decisions_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED_STEP:  step_cfg  = cfg_data[STEP_W-1:0];
          REG_SPEED_LIMIT: limit_cfg = cfg_data;
          REG_GAP:         gap_cfg   = cfg_data[GAP_W-1:0];
          REG_CENTRE_TOL:  tol_cfg   = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) plan_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decisions_due.size() == 0) begin
          errs++;
          $display("%0t result transaction expected none actual %h", $time, m_axis_tdata);
        end else begin
          dec = decisions_due.pop_front();
          check_field("mode", dec.mode, m_axis_tdata[1:0]);
          check_field("target_lane", dec.lane, m_axis_tdata[3:2]);
          check_field("ref_speed", dec.speed, m_axis_tdata[19:4]);
          check_field("car_ahead", dec.near, m_axis_tdata[20]);
        end
      end
    end
    owed       <= decisions_due.size();
    mismatches <= errs;
  end

endmodule

>>> bench/tb_top.sv
module tb_top
  import lkcp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACT_SPARE     = 3;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int S_MAX         = 524287;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  int owed;
  int mismatches;
  int src_idle = 0;
  int sink_stall = 0;
  int anchor_s = 0;
  int quiet = 0;

  lane_keep_change_planner_unit dut (.*);
  lkcp_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall);

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("FAIL lane_keep_change_planner_unit");
    $finish;
  end

  function automatic int clamp_s(input int v);
    if (v < 0) return 0;
    if (v > S_MAX) return S_MAX;
    return v;
  endfunction

  task automatic send_item(input int act, pts, es, ed, pes, os, od, vx, vy);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act[1:0];
    s_axis_tdata  <= {5'd0, vy[12:0], vx[12:0], od[11:0], os[18:0], pes[18:0], ed[11:0],
                      es[18:0], pts[7:0]};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic random_item(input int act);
    int pts, es, ed, pes, os, od, vx, vy, roll;
    pts = $urandom;
    es  = $urandom;
    ed  = $urandom;
    pes = $urandom;
    os  = $urandom;
    od  = $urandom;
    vx  = $urandom;
    vy  = $urandom;
    if (act == ACT_BEGIN) begin
      roll = $urandom_range(99);
      pts  = (roll < 40) ? 0 : (roll < 85) ? int'($urandom_range(1, 50)) : int'($urandom_range(255));
      es   = $urandom_range(0, S_MAX);
      pes  = clamp_s(es + int'($urandom_range(0, 3000)));
      roll = $urandom_range(99);
      // mostly near a lane centre so lane changes can finish
      if (roll < 50) ed = 128 + int'($urandom_range(0, 20)) - 10;
      else if (roll < 75) ed = 384 + int'($urandom_range(0, 20)) - 10;
      anchor_s = (pts[7:0] != 0) ? pes : es;
    end else if (act == ACT_CAR) begin
      if ($urandom_range(99) < 75)
        od = 128 + 256 * int'($urandom_range(0, 2)) + int'($urandom_range(0, 300)) - 150;
      if ($urandom_range(99) < 75) begin
        vx = int'($urandom_range(0, 800)) - 400;
        vy = int'($urandom_range(0, 800)) - 400;
      end
      if ($urandom_range(99) < 80) os = clamp_s(anchor_s + int'($urandom_range(0, 4000)) - 2000);
    end
    send_item(act, pts, es, ed, pes, os, od, vx, vy);
  endtask

  task automatic write_reg(input reg_index_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input int stp, lim, gp, tl);
    write_reg(REG_SPEED_STEP, stp);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_GAP, gp);
    write_reg(REG_CENTRE_TOL, tl);
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every decision has come back, then let cars finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int counted, n, act;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // a decide before any begin uses the reset frame
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 0, 1000, 384, 77, 0, 0, 0, 0);
    // lane edges are exclusive
    send_item(ACT_CAR, 0, 0, 0, 0, 1100, 512, 0, 0);
    send_item(ACT_CAR, 0, 0, 0, 0, 1100, 256, 0, 0);
    // level with the reference, then exactly at the gap
    send_item(ACT_CAR, 0, 0, 0, 0, 1000, 385, 0, 0);
    send_item(ACT_CAR, 0, 0, 0, 0, 2920, 383, 0, 0);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 255, 0, -1024, S_MAX, 0, 0, 0, 0);
    send_item(ACT_CAR, 0, 0, 0, 0, 0, 384, -4096, -4096);
    send_item(ACT_CAR, 0, 0, 0, 0, S_MAX, 384, 3, -4);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    // near flag persists across decide
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 0, S_MAX, 2047, 0, 0, 0, 0, 0);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 0, 10, 134, 0, 0, 0, 0, 0);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 1, 0, 128, 5000, 0, 0, 0, 0);
    send_item(ACT_CAR, 0, 0, 0, 0, 4990, -127, -4096, 0);
    send_item(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_CAR, 0, 0, 0, 0, 0, 2047, 0, 0);
    send_item(ACT_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_regs(STEP_RST, LIMIT_RST, GAP_RST, TOL_RST);
        1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 255);
        2: load_regs(0, 0, 0, 1);
        3: load_regs(4095, 65535, 16383, 0);
        4: load_regs($urandom, $urandom, $urandom, $urandom);
        5: load_regs(1, 65535, 16383, 255);
        6: load_regs($urandom_range(1, 400), $urandom_range(0, 65535),
                     $urandom_range(500, 4000), $urandom_range(1, 40));
        default: load_regs($urandom, $urandom, $urandom, $urandom);
      endcase
      case (ph % 4)
        0: begin
          src_idle = 0;
          sink_stall = 0;
        end
        1: begin
          src_idle = 50;
          sink_stall = 0;
        end
        2: begin
          src_idle = 0;
          sink_stall = 50;
        end
        default: begin
          src_idle = 20;
          sink_stall = 20;
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          n = $urandom_range(0, 8);
          random_item(ACT_BEGIN);
          repeat (n) random_item(ACT_CAR);
          random_item(ACT_DECIDE);
          counted += n + 2;
        end else begin
          // stray items outside a frame
          act = $urandom_range(0, 3);
          random_item(act);
          if (act != ACT_SPARE) counted++;
        end
      end
      settle();
    end

    if (mismatches == 0 && owed == 0) begin
      $display("PASS lane_keep_change_planner_unit");
    end else begin
      $display("FAIL lane_keep_change_planner_unit");
    end
    $finish;
  end

endmodule
